FILE: design/rlbs_pkg.sv
// ----------------------------------------------------------------------------
// rlbs_pkg
// Types and codes shared by the radio locator beacon sequencer modules.
// ----------------------------------------------------------------------------
package rlbs_pkg;

  // sequencer phases
  localparam logic [2:0] PH_INIT     = 3'd0;
  localparam logic [2:0] PH_SLEEP    = 3'd1;
  localparam logic [2:0] PH_RECEIVE  = 3'd2;
  localparam logic [2:0] PH_TRANSMIT = 3'd3;
  localparam logic [2:0] PH_WAITTX   = 3'd4;

  // radio commands
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_SETUP  = 3'd1,
    CMD_LISTEN = 3'd2,
    CMD_SLEEP  = 3'd3,
    CMD_TX     = 3'd4
  } radio_cmd_e;

  // configuration register indexes
  localparam logic [2:0] REG_SLEEP_MS        = 3'd0;
  localparam logic [2:0] REG_SHORT_LISTEN_MS = 3'd1;
  localparam logic [2:0] REG_LONG_LISTEN_MS  = 3'd2;
  localparam logic [2:0] REG_TX_TIMEOUT_MS   = 3'd3;

  localparam logic [15:0] SLEEP_MS_RST        = 16'd55000;
  localparam logic [15:0] SHORT_LISTEN_MS_RST = 16'd5000;
  localparam logic [15:0] LONG_LISTEN_MS_RST  = 16'd60000;
  localparam logic [15:0] TX_TIMEOUT_MS_RST   = 16'd400;

  // fix-age thresholds, in units of 1024 ms
  localparam logic [21:0] AGE_TH6 = 22'd3515;
  localparam logic [21:0] AGE_TH5 = 22'd585;
  localparam logic [21:0] AGE_TH4 = 22'd59;
  localparam logic [21:0] AGE_TH3 = 22'd10;
  localparam logic [21:0] AGE_TH2 = 22'd1;

  localparam logic [3:0] MAX_NIBBLE = 4'hF;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               rx_done;
    logic               crc_error;
    logic               tx_done;
    logic [7:0]         rx_rssi;
    logic [7:0]         rx_power_request;
    logic               gps_fix_valid;
    logic [15:0]        gps_dop;
    logic [31:0]        last_fix_ms;
    logic signed [31:0] fix_lat;
    logic signed [31:0] fix_lon;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  radio_command;
    logic [3:0]  tx_power;
    logic [47:0] tx_payload;
    logic [2:0]  phase;
  } out_item_t;

  typedef struct packed {
    logic [15:0] sleep_ms;
    logic [15:0] short_listen_ms;
    logic [15:0] long_listen_ms;
    logic [15:0] tx_timeout_ms;
  } cfg_t;

endpackage

FILE: design/radio_locator_beacon_sequencer_top.sv
// ----------------------------------------------------------------------------
// radio_locator_beacon_sequencer_top
// Poll-driven radio locator sequencer: one radio command per poll.
// ----------------------------------------------------------------------------
// Each accepted poll is captured in an input register, evaluated by the phase
// logic and payload packer combinationally, and its result lands in an output
// register; the phase state updates at that same edge. A new poll is taken
// every cycle while the output side keeps up; the single output register sets
// the throughput of one poll per cycle. Configuration writes are applied at
// once and should only be made while no poll is in flight.
module radio_locator_beacon_sequencer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rlbs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rlbs_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i
);
  import rlbs_pkg::*;

  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;
  cfg_t      cfg_q;
  out_item_t res;
  logic      advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  rlbs_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_ms        <= SLEEP_MS_RST;
      cfg_q.short_listen_ms <= SHORT_LISTEN_MS_RST;
      cfg_q.long_listen_ms  <= LONG_LISTEN_MS_RST;
      cfg_q.tx_timeout_ms   <= TX_TIMEOUT_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SLEEP_MS:        cfg_q.sleep_ms        <= cfg_wdata_i;
        REG_SHORT_LISTEN_MS: cfg_q.short_listen_ms <= cfg_wdata_i;
        REG_LONG_LISTEN_MS:  cfg_q.long_listen_ms  <= cfg_wdata_i;
        REG_TX_TIMEOUT_MS:   cfg_q.tx_timeout_ms   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // power and payload only ride with a transmit command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.radio_command != CMD_TX) |->
      (out_data_o.tx_power == 4'd0) && (out_data_o.tx_payload == 48'd0))
    else $error("payload or power outside transmit");

  // a transmit always moves on to waiting for transmit done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.radio_command == CMD_TX) |->
      (out_data_o.phase == PH_WAITTX))
    else $error("transmit without wait phase");

  // setup is only ever followed by sleep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.radio_command == CMD_SETUP) |->
      (out_data_o.phase == PH_SLEEP))
    else $error("setup without sleep phase");

  // input stage only stalls when it holds a poll that cannot move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stall without backpressure");
`endif

endmodule

FILE: design/rlbs_payload.sv
// ----------------------------------------------------------------------------
// rlbs_payload
// Builds the six-byte locator payload: flag/DOP/age byte, RSSI, coordinate.
// ----------------------------------------------------------------------------
module rlbs_payload (
  input  rlbs_pkg::in_item_t item_i,
  input  logic               lat_turn_i,
  input  logic [7:0]         rssi_i,
  output logic [47:0]        payload_o
);
  import rlbs_pkg::*;

  logic [8:0]  dop_shr;
  logic [3:0]  dop_code;
  logic [31:0] age_ms;
  logic [21:0] age;
  logic [2:0]  age_code;
  logic [7:0]  byte0;
  logic [31:0] coord;

  always_comb begin
    dop_shr  = item_i.gps_dop[15:7];
    dop_code = (dop_shr > 9'(MAX_NIBBLE)) ? MAX_NIBBLE : dop_shr[3:0];
    age_ms   = item_i.now_ms - item_i.last_fix_ms;
    age      = age_ms[31:10];

    if (item_i.last_fix_ms == 32'd0) begin
      age_code = 3'd0;
    end else if (age > AGE_TH6) begin
      age_code = 3'd6;
    end else if (age > AGE_TH5) begin
      age_code = 3'd5;
    end else if (age > AGE_TH4) begin
      age_code = 3'd4;
    end else if (age > AGE_TH3) begin
      age_code = 3'd3;
    end else if (age > AGE_TH2) begin
      age_code = 3'd2;
    end else begin
      age_code = 3'd1;
    end

    if (item_i.gps_fix_valid) begin
      byte0 = {lat_turn_i, dop_code, age_code};
      coord = lat_turn_i ? item_i.fix_lat : item_i.fix_lon;
    end else begin
      // no fix: the first byte holds only the lat/lon flag and the coordinate is zero
      byte0 = {lat_turn_i, 7'd0};
      coord = 32'd0;
    end

    payload_o = {byte0, rssi_i, coord};
  end

endmodule

FILE: design/rlbs_fsm.sv
// ----------------------------------------------------------------------------
// rlbs_fsm
// Five-phase radio sequencer with deadline timing and saved link data.
// ----------------------------------------------------------------------------
module rlbs_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  rlbs_pkg::in_item_t  item_i,
  input  rlbs_pkg::cfg_t      cfg_i,
  output rlbs_pkg::out_item_t res_o
);
  import rlbs_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] deadline_q, deadline_d;
  logic        lat_turn_q, lat_turn_d;
  logic [7:0]  rssi_q, rssi_d;
  logic [7:0]  power_q, power_d;

  logic [31:0] diff;
  logic        passed;
  logic [47:0] built;
  radio_cmd_e  cmd;
  logic [3:0]  pwr;
  logic [47:0] payload;

  rlbs_payload u_payload (
    .item_i     (item_i),
    .lat_turn_i (~lat_turn_q),
    .rssi_i     (rssi_q),
    .payload_o  (built)
  );

  // wrap-safe deadline test
  assign diff   = item_i.now_ms - deadline_q;
  assign passed = (diff != 32'd0) && !diff[31];

  always_comb begin
    phase_d    = phase_q;
    deadline_d = deadline_q;
    lat_turn_d = lat_turn_q;
    rssi_d     = rssi_q;
    power_d    = power_q;
    cmd        = CMD_NONE;
    pwr        = 4'd0;
    payload    = 48'd0;

    unique case (phase_q)
      PH_SLEEP: begin
        if (passed) begin
          cmd        = CMD_LISTEN;
          phase_d    = PH_RECEIVE;
          deadline_d = item_i.now_ms + 32'(cfg_i.short_listen_ms);
        end
      end
      PH_RECEIVE: begin
        if (item_i.rx_done) begin
          if (item_i.crc_error) begin
            cmd = CMD_LISTEN;
          end else begin
            rssi_d  = item_i.rx_rssi;
            power_d = item_i.rx_power_request;
            cmd     = CMD_SLEEP;
            phase_d = PH_TRANSMIT;
          end
        end else if (passed) begin
          cmd        = CMD_SLEEP;
          phase_d    = PH_SLEEP;
          deadline_d = item_i.now_ms + 32'(cfg_i.sleep_ms);
        end
      end
      PH_TRANSMIT: begin
        lat_turn_d = ~lat_turn_q;
        payload    = built;
        pwr        = (power_q > 8'(MAX_NIBBLE)) ? MAX_NIBBLE : power_q[3:0];
        cmd        = CMD_TX;
        deadline_d = item_i.now_ms + 32'(cfg_i.tx_timeout_ms);
        phase_d    = PH_WAITTX;
      end
      PH_WAITTX: begin
        if (item_i.tx_done) begin
          cmd        = CMD_LISTEN;
          phase_d    = PH_RECEIVE;
          deadline_d = item_i.now_ms + 32'(cfg_i.long_listen_ms);
        end else if (passed) begin
          cmd        = CMD_SLEEP;
          phase_d    = PH_SLEEP;
          deadline_d = item_i.now_ms + 32'(cfg_i.sleep_ms);
        end
      end
      default: begin
        // init and unused codes
        cmd        = CMD_SETUP;
        phase_d    = PH_SLEEP;
        deadline_d = item_i.now_ms + 32'(cfg_i.sleep_ms);
      end
    endcase

    res_o.radio_command = cmd;
    res_o.tx_power      = pwr;
    res_o.tx_payload    = payload;
    res_o.phase         = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_INIT;
      deadline_q <= 32'd0;
      lat_turn_q <= 1'b0;
      rssi_q     <= 8'd0;
      power_q    <= 8'd0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      deadline_q <= deadline_d;
      lat_turn_q <= lat_turn_d;
      rssi_q     <= rssi_d;
      power_q    <= power_d;
    end
  end

endmodule
